### design/bcsg_pkg.sv
package bcsg_pkg;

    localparam int FRAC_BITS = 12;
    localparam int XW        = FRAC_BITS + 1;
    localparam int KW        = $clog2(FRAC_BITS);
    localparam int SH0       = 16 - FRAC_BITS;

    localparam logic [XW-1:0] ONE  = XW'(1 << FRAC_BITS);
    localparam logic [XW-1:0] HALF = XW'(1 << (FRAC_BITS - 1));

    localparam int TONE_LAT  = 7;
    localparam int POWER_LAT = 22;
    localparam int LAT       = TONE_LAT + POWER_LAT;

    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_CONTRAST   = 2'd1;
    localparam logic [1:0] REG_SATURATION = 2'd2;
    localparam logic [1:0] REG_INV_GAMMA  = 2'd3;

    localparam logic [15:0] LUMA_COEF [3] = '{16'd13933, 16'd46871, 16'd4732};

    typedef struct packed {
        logic [7:0] alpha_in;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] alpha_out;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    typedef struct packed {
        logic signed [9:0] brightness;
        logic [9:0]        contrast;
        logic [9:0]        saturation;
        logic [11:0]       inv_gamma;
        logic              sat_skip;
        logic              gam_skip;
        logic              identity;
    } cfg_t;

    typedef logic [XW-1:0] scale_lut_t [256];

    function automatic scale_lut_t build_scale_lut();
        scale_lut_t t;
        for (int c = 0; c < 256; c++)
        begin
            t[c] = XW'((c * (1 << FRAC_BITS) * 2 + 255) / 510);
        end
        return t;
    endfunction

    localparam scale_lut_t SCALE_LUT = build_scale_lut();

endpackage

### design/brightness_contrast_saturation_gamma.sv
// Channel | Handshake                  | Word
// pixel   | pixel_valid / pixel_stall  | pixel_in_t  (alpha, red, green, blue)
// result  | result_valid / result_stall| pixel_out_t (alpha, red, green, blue)
// config  | APB psel/penable/pwrite    | paddr[3:2] selects register, pwdata
//
// One word per clock while a stalled result does not freeze the pipeline; 7 tone stages,
// 22 power stages (the 16-step log2 squaring chain sets the depth).
// Reset clears the registers to identity and empties the pipeline.
// A valid result held by result_stall freezes the whole pipeline; pixel_stall follows.
module brightness_contrast_saturation_gamma
    import bcsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  pixel_in_t   pixel,
    output logic        result_valid,
    input  logic        result_stall,
    output pixel_out_t  result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef struct packed {
        logic      bypass;
        pixel_in_t pix;
    } side_t;

    cfg_t          cfg;
    logic          en;
    logic [LAT-1:0] vld_reg;
    side_t         side_reg [LAT];
    logic [7:0]    chan [3];
    logic [XW-1:0] tone_x [3];
    logic [7:0]    out_c [3];

    bcsg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en          = !(vld_reg[LAT-1] && result_stall);
    assign pixel_stall = !en;

    assign chan[0] = pixel.red_in;
    assign chan[1] = pixel.green_in;
    assign chan[2] = pixel.blue_in;

    bcsg_tone u_tone (
        .clk   (clk),
        .en    (en),
        .cfg   (cfg),
        .chan  (chan),
        .x_out (tone_x)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_power
        bcsg_power u_power (
            .clk       (clk),
            .en        (en),
            .gam_skip  (cfg.gam_skip),
            .inv_gamma (cfg.inv_gamma),
            .x_in      (tone_x[i]),
            .y_out     (out_c[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], pixel_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].bypass <= (pixel.alpha_in == 8'd0) || cfg.identity;
            side_reg[0].pix    <= pixel;
            for (int s = 1; s < LAT; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign result_valid     = vld_reg[LAT-1];
    assign result.alpha_out = side_reg[LAT-1].pix.alpha_in;
    assign result.red_out   = side_reg[LAT-1].bypass ? side_reg[LAT-1].pix.red_in   : out_c[0];
    assign result.green_out = side_reg[LAT-1].bypass ? side_reg[LAT-1].pix.green_in : out_c[1];
    assign result.blue_out  = side_reg[LAT-1].bypass ? side_reg[LAT-1].pix.blue_in  : out_c[2];

endmodule

### design/bcsg_regs.sv
module bcsg_regs
    import bcsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [9:0]  bri_reg;
    logic [9:0]  con_reg;
    logic [9:0]  sat_reg;
    logic [11:0] gam_reg;
    logic signed [9:0] bri_s;
    logic [9:0]  con_c;
    logic [9:0]  sat_c;
    logic [11:0] gam_c;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bri_reg <= 10'd0;
            con_reg <= 10'd256;
            sat_reg <= 10'd256;
            gam_reg <= 12'd256;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_BRIGHTNESS: bri_reg <= pwdata[9:0];
                REG_CONTRAST:   con_reg <= pwdata[9:0];
                REG_SATURATION: sat_reg <= pwdata[9:0];
                REG_INV_GAMMA:  gam_reg <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BRIGHTNESS: prdata = {22'd0, bri_reg};
            REG_CONTRAST:   prdata = {22'd0, con_reg};
            REG_SATURATION: prdata = {22'd0, sat_reg};
            REG_INV_GAMMA:  prdata = {20'd0, gam_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        bri_s = $signed(bri_reg);
        if (bri_s < -10'sd256)
            bri_s = -10'sd256;
        else if (bri_s > 10'sd256)
            bri_s = 10'sd256;
        con_c = (con_reg > 10'd512) ? 10'd512 : con_reg;
        sat_c = (sat_reg > 10'd512) ? 10'd512 : sat_reg;
        if (gam_reg < 12'd85)
            gam_c = 12'd85;
        else if (gam_reg > 12'd2560)
            gam_c = 12'd2560;
        else
            gam_c = gam_reg;
    end

    assign cfg.brightness = bri_s;
    assign cfg.contrast   = con_c;
    assign cfg.saturation = sat_c;
    assign cfg.inv_gamma  = gam_c;
    assign cfg.sat_skip   = (sat_c == 10'd256);
    assign cfg.gam_skip   = (gam_c == 12'd256);
    assign cfg.identity   = (bri_s == 10'sd0) && (con_c == 10'd256)
                            && (sat_c == 10'd256) && (gam_c == 12'd256);

endmodule

### design/bcsg_tone.sv
module bcsg_tone
    import bcsg_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  cfg_t          cfg,
    input  logic [7:0]    chan [3],
    output logic [XW-1:0] x_out [3]
);

    logic [XW-1:0]      x1_reg [3];
    logic signed [24:0] cp2_reg [3];
    logic [XW-1:0]      c3_reg [3];
    logic [28:0]        lp4_reg [3];
    logic [XW-1:0]      c4_reg [3];
    logic [XW-1:0]      y5_reg;
    logic [XW-1:0]      c5_reg [3];
    logic signed [24:0] dp6_reg [3];
    logic [XW-1:0]      y6_reg;
    logic [XW-1:0]      c6_reg [3];
    logic [XW-1:0]      c7_reg [3];

    logic signed [23:0] bterm;
    logic [XW-1:0]      c3_next [3];
    logic [XW-1:0]      c7_next [3];
    logic [29:0]        lsum;
    logic [29:0]        y5_next;
    logic signed [24:0] v3;
    logic signed [24:0] v7;

    assign bterm = ((24'(cfg.brightness) <<< FRAC_BITS) + 24'sd256) >>> 9;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v3 = ((cp2_reg[i] + 25'sd128) >>> 8) + 25'sd2048 + 25'(bterm);
            if (v3 < 25'sd0)
                c3_next[i] = '0;
            else if (v3 > $signed(25'(ONE)))
                c3_next[i] = ONE;
            else
                c3_next[i] = v3[XW-1:0];
        end
        lsum    = 30'(lp4_reg[0]) + 30'(lp4_reg[1]) + 30'(lp4_reg[2]);
        y5_next = lsum + 30'd32768;
        for (int i = 0; i < 3; i++)
        begin
            v7 = 25'($signed({1'b0, y6_reg})) + ((dp6_reg[i] + 25'sd128) >>> 8);
            if (cfg.sat_skip)
                c7_next[i] = c6_reg[i];
            else if (v7 < 25'sd0)
                c7_next[i] = '0;
            else if (v7 > $signed(25'(ONE)))
                c7_next[i] = ONE;
            else
                c7_next[i] = v7[XW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                x1_reg[i]  <= SCALE_LUT[chan[i]];
                cp2_reg[i] <= 25'($signed({1'b0, x1_reg[i]}) - $signed({1'b0, HALF}))
                              * 25'($signed({1'b0, cfg.contrast}));
                c3_reg[i]  <= c3_next[i];
                lp4_reg[i] <= 29'(c3_reg[i]) * 29'(LUMA_COEF[i]);
                c4_reg[i]  <= c3_reg[i];
                c5_reg[i]  <= c4_reg[i];
                dp6_reg[i] <= 25'($signed({1'b0, c5_reg[i]}) - $signed({1'b0, y5_reg}))
                              * 25'($signed({1'b0, cfg.saturation}));
                c6_reg[i]  <= c5_reg[i];
                c7_reg[i]  <= c7_next[i];
            end
            y5_reg <= y5_next[16 +: XW];
            y6_reg <= y5_reg;
        end
    end

    assign x_out = c7_reg;

endmodule

### design/bcsg_power.sv
module bcsg_power
    import bcsg_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic          gam_skip,
    input  logic [11:0]   inv_gamma,
    input  logic [XW-1:0] x_in,
    output logic [7:0]    y_out
);

    logic [30:0]        m_reg    [17];
    logic [KW-1:0]      k_reg    [17];
    logic [15:0]        fr_reg   [17];
    logic               pass_reg [20];
    logic [XW-1:0]      x_reg    [20];
    logic signed [33:0] lg_reg;
    logic [15:0]        f_reg;
    logic signed [9:0]  n18_reg;
    logic [30:0]        q1_reg;
    logic [31:0]        fq_reg;
    logic signed [9:0]  n19_reg;
    logic [XW-1:0]      res_reg;
    logic [7:0]         y_reg;

    logic [KW-1:0]      k0;
    logic [61:0]        sq   [16];
    logic [30:0]        m_nx [16];
    logic               fb   [16];
    logic signed [20:0] l17;
    logic signed [25:0] e18;
    logic [16:0]        q19;
    logic [17:0]        p20;
    logic signed [11:0] sh20;
    logic [5:0]         sa;
    logic [39:0]        r20;
    logic [XW-1:0]      res_next;
    logic [20:0]        o21;

    always_comb
    begin
        k0 = '0;
        for (int b = 1; b < FRAC_BITS; b++)
        begin
            if (x_in[b])
                k0 = KW'(b);
        end
    end

    always_comb
    begin
        for (int s = 0; s < 16; s++)
        begin
            sq[s] = 62'(m_reg[s]) * 62'(m_reg[s]);
            fb[s] = sq[s][61];
            m_nx[s] = fb[s] ? sq[s][61:31] : sq[s][60:30];
        end
    end

    assign l17 = $signed({5'(21'(k_reg[16]) - 21'(FRAC_BITS)), fr_reg[16]});
    assign e18 = 26'((lg_reg + 34'sd128) >>> 8);
    assign q19 = 17'd43024 + 17'(q1_reg[30:16]);
    assign p20 = 18'd65536 + 18'(fq_reg[31:16]);
    assign sh20 = 12'(SH0) - 12'(n19_reg);
    assign sa   = sh20[5:0];

    always_comb
    begin
        if (sa == 6'd0)
            r20 = 40'(p20);
        else
            r20 = (40'(p20) + (40'd1 << (sa - 6'd1))) >> sa;
        if (pass_reg[19])
            res_next = x_reg[19];
        else if (sh20 < 12'sd0)
            res_next = ONE;
        else if (sh20 >= 12'sd40)
            res_next = '0;
        else if (r20 > 40'(ONE))
            res_next = ONE;
        else
            res_next = r20[XW-1:0];
    end

    assign o21 = ((21'(res_reg) << 8) - 21'(res_reg) + 21'(HALF)) >> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]    <= 31'(x_in[FRAC_BITS-1:0]) << (5'd30 - 5'(k0));
            k_reg[0]    <= k0;
            fr_reg[0]   <= '0;
            pass_reg[0] <= gam_skip || (x_in == '0) || x_in[FRAC_BITS];
            x_reg[0]    <= x_in;
            for (int s = 0; s < 16; s++)
            begin
                m_reg[s+1]  <= m_nx[s];
                k_reg[s+1]  <= k_reg[s];
                fr_reg[s+1] <= fr_reg[s] | (fb[s] ? (16'd1 << (15 - s)) : 16'd0);
            end
            for (int s = 1; s < 20; s++)
            begin
                pass_reg[s] <= pass_reg[s-1];
                x_reg[s]    <= x_reg[s-1];
            end
            lg_reg  <= 34'(l17) * 34'($signed({1'b0, inv_gamma}));
            f_reg   <= e18[15:0];
            n18_reg <= e18[25:16];
            q1_reg  <= 31'(e18[15:0]) * 31'd22512;
            fq_reg  <= 32'(f_reg) * 32'(q19);
            n19_reg <= n18_reg;
            res_reg <= res_next;
            y_reg   <= o21[7:0];
        end
    end

    assign y_out = y_reg;

endmodule
